// ----- hdl/murmur2_64b_word_hasher_defines.svh -----
// assertion macros shared by the checker of the word hasher
`ifndef MURMUR2_64B_WORD_HASHER_DEFINES_SVH
`define MURMUR2_64B_WORD_HASHER_DEFINES_SVH

// property checked out of reset
`define MWH_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: property violated");

// property checked at every edge, reset included
`define MWH_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: property violated");

`endif

// ----- hdl/mwh_pkg.sv -----
// constants and shared types of the murmur2 64-bit word hasher
package mwh_pkg;

    localparam logic [31:0] MIX_MUL    = 32'h5bd1e995;
    localparam int          MIX_SHIFT  = 24;
    localparam logic [31:0] SEED_RESET = 32'h00FF13FF;
    localparam int          FIN_SH1    = 18;
    localparam int          FIN_SH2    = 22;
    localparam int          FIN_SH3    = 17;
    localparam int          FIN_SH4    = 19;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MIX1,
        OP_MIX2,
        OP_LANE,
        OP_TAIL,
        OP_FIN1,
        OP_FIN2,
        OP_FIN3,
        OP_FIN4,
        OP_EMIT
    } t_op;

    // item facts the controller needs to pick its path
    typedef struct packed {
        logic full_word;
        logic part_word;
        logic last_item;
    } t_dp_status;

endpackage

// ----- hdl/mwh_datapath.sv -----
// lane registers, mix register and the shared constant multiplier
module mwh_datapath
    import mwh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_op         i_op,
    input  logic        i_seed_we,
    input  logic [31:0] i_seed,
    input  logic [31:0] i_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_first_word,
    input  logic        i_last_word,
    input  logic [31:0] i_total_length,
    output t_dp_status  o_status,
    output logic [63:0] o_hash_value
);

    logic [31:0] r_seed;
    logic [31:0] r_lane_one;
    logic [31:0] r_lane_two;
    logic        r_toggle;
    logic [31:0] r_word;
    logic [31:0] r_k;
    logic        r_last;
    logic [63:0] r_hash;
    logic [31:0] n_word;
    logic [31:0] w_mul_a;
    logic [31:0] w_prod;

    // mask off bytes beyond the byte count
    always_comb begin
        unique case (i_byte_count)
            3'd1:    n_word = i_word & 32'h0000_00FF;
            3'd2:    n_word = i_word & 32'h0000_FFFF;
            3'd3:    n_word = i_word & 32'h00FF_FFFF;
            default: n_word = i_word;
        endcase
    end

    // multiplier operand select
    always_comb begin
        unique case (i_op)
            OP_MIX1: w_mul_a = r_word;
            OP_MIX2: w_mul_a = r_k ^ (r_k >> MIX_SHIFT);
            OP_LANE: w_mul_a = r_toggle ? r_lane_two : r_lane_one;
            OP_TAIL: w_mul_a = r_lane_two ^ r_word;
            OP_FIN1: w_mul_a = r_lane_one ^ (r_lane_two >> FIN_SH1);
            OP_FIN2: w_mul_a = r_lane_two ^ (r_lane_one >> FIN_SH2);
            OP_FIN3: w_mul_a = r_lane_one ^ (r_lane_two >> FIN_SH3);
            OP_FIN4: w_mul_a = r_lane_two ^ (r_lane_one >> FIN_SH4);
            default: w_mul_a = r_word;
        endcase
    end

    // shared multiplier, low word kept
    assign w_prod = w_mul_a * MIX_MUL;

    // seed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RESET;
        end else if (i_seed_we) begin
            r_seed <= i_seed;
        end
    end

    // lane state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane_one <= '0;
            r_lane_two <= '0;
            r_toggle   <= 1'b0;
        end else begin
            unique case (i_op)
                OP_LOAD: begin
                    if (i_first_word) begin
                        r_lane_one <= r_seed ^ i_total_length;
                        r_lane_two <= '0;
                        r_toggle   <= 1'b0;
                    end
                end
                OP_LANE: begin
                    if (r_toggle) begin
                        r_lane_two <= w_prod ^ r_k;
                    end else begin
                        r_lane_one <= w_prod ^ r_k;
                    end
                    r_toggle <= ~r_toggle;
                end
                OP_TAIL: r_lane_two <= w_prod;
                OP_FIN1: r_lane_one <= w_prod;
                OP_FIN2: r_lane_two <= w_prod;
                OP_FIN3: r_lane_one <= w_prod;
                OP_FIN4: begin
                    r_lane_two <= w_prod;
                    r_toggle   <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // item capture, mix value and result payload
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_LOAD: begin
                r_word <= n_word;
                r_last <= i_last_word;
            end
            OP_MIX1: r_k <= w_prod;
            OP_MIX2: r_k <= w_prod;
            OP_EMIT: r_hash <= {r_lane_one, r_lane_two};
            default: begin
            end
        endcase
    end

    assign o_status.full_word = i_byte_count[2];
    assign o_status.part_word = !i_byte_count[2] && (i_byte_count[1:0] != 2'd0);
    assign o_status.last_item = (i_op == OP_LOAD) ? i_last_word : r_last;
    assign o_hash_value       = r_hash;

endmodule

// ----- hdl/mwh_ctrl.sv -----
// sequencer that steps the datapath through mix, tail and finalization
module mwh_ctrl
    import mwh_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output t_op        o_op,
    output logic       o_in_stall,
    output logic       o_out_valid
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MIX1,
        S_MIX2,
        S_LANE,
        S_TAIL,
        S_FIN1,
        S_FIN2,
        S_FIN3,
        S_FIN4,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    // operation and next state
    always_comb begin
        o_op    = OP_NONE;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op = OP_LOAD;
                    priority if (i_status.full_word) begin
                        n_state = S_MIX1;
                    end else if (i_status.part_word) begin
                        n_state = S_TAIL;
                    end else if (i_status.last_item) begin
                        n_state = S_FIN1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_MIX1: begin
                o_op    = OP_MIX1;
                n_state = S_MIX2;
            end
            S_MIX2: begin
                o_op    = OP_MIX2;
                n_state = S_LANE;
            end
            S_LANE: begin
                o_op    = OP_LANE;
                n_state = i_status.last_item ? S_FIN1 : S_IDLE;
            end
            S_TAIL: begin
                o_op    = OP_TAIL;
                n_state = i_status.last_item ? S_FIN1 : S_IDLE;
            end
            S_FIN1: begin
                o_op    = OP_FIN1;
                n_state = S_FIN2;
            end
            S_FIN2: begin
                o_op    = OP_FIN2;
                n_state = S_FIN3;
            end
            S_FIN3: begin
                o_op    = OP_FIN3;
                n_state = S_FIN4;
            end
            S_FIN4: begin
                o_op    = OP_FIN4;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    o_op    = OP_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ----- hdl/murmur2_64b_word_hasher.sv -----
// Streaming murmur2 64-bit hasher: one 32-bit key word per item, one 64-bit result per key.
// Every multiplication goes through a single shared 32x32 constant multiplier, so an item is first
// taken in and then runs one multiplier step after another: a full word needs two mix multiplies
// and one lane multiply, a partial word one tail multiply, an empty word no multiply at all.
// A last item adds finalization steps FIN1 to FIN4 and a load of the result register, which
// then holds the result while the next key already streams in; a second result waits for the
// first to be taken. The seed may only be written while no key is in flight.
module murmur2_64b_word_hasher
    import mwh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_seed_we,
    input  logic [31:0] i_seed,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_first_word,
    input  logic        i_last_word,
    input  logic [31:0] i_total_length,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_hash_value
);

    t_op        w_op;
    t_dp_status w_status;

    // sequencer
    mwh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_op        (w_op),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // lanes and multiplier
    mwh_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (w_op),
        .i_seed_we      (i_seed_we),
        .i_seed         (i_seed),
        .i_word         (i_word),
        .i_byte_count   (i_byte_count),
        .i_first_word   (i_first_word),
        .i_last_word    (i_last_word),
        .i_total_length (i_total_length),
        .o_status       (w_status),
        .o_hash_value   (o_hash_value)
    );

endmodule

// ----- hdl/mwh_checker.sv -----
// port-level checks of the word hasher and their bind
`include "murmur2_64b_word_hasher_defines.svh"

module mwh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_seed_we,
    input logic [31:0] i_seed,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [31:0] i_word,
    input logic [2:0]  i_byte_count,
    input logic        i_first_word,
    input logic        i_last_word,
    input logic [31:0] i_total_length,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [63:0] o_hash_value
);

    logic w_in_acc;
    logic w_busy_acc;
    logic w_full_acc;

    assign w_in_acc = i_in_valid && !o_in_stall;

    // accepted item that has bytes to absorb or a key to finish
    assign w_busy_acc = w_in_acc && (i_last_word || (i_byte_count != 3'd0));

    // accepted full word that does not end a key
    assign w_full_acc = w_in_acc && i_byte_count[2] && !i_last_word;

    // reset empties the result register and frees the input
    `MWH_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> (!o_out_valid && !o_in_stall))

    // an item with work holds the input for at least the next cycle
    `MWH_ASSERT(a_busy_after_acc, i_clk, i_rst_n, w_busy_acc |=> o_in_stall)

    // a full non-last word frees the input again once its mix and lane steps are done
    `MWH_ASSERT(a_full_word_rate, i_clk, i_rst_n, w_full_acc |-> ##4 !o_in_stall)

    // a stalled result stays
    `MWH_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_hash_value)))

endmodule

bind murmur2_64b_word_hasher mwh_checker u_mwh_checker (.*);
